@@ hdl/rlcm_pkg.sv @@
// Shared types and constants of the rpm LED color mapper.
`timescale 1ns / 1ps

package rlcm_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned LedCountDef   = 14;
  localparam int unsigned ChCount       = 3;
  localparam int unsigned LedIdxW       = 4;
  localparam int unsigned MaskW         = 14;
  localparam int unsigned RpmW          = 15;
  localparam int unsigned ProdW         = 23;
  localparam int unsigned QuotW         = 8;

  localparam logic [1:0] ActClear = 2'd0;
  localparam logic [1:0] ActAdd   = 2'd1;
  localparam logic [1:0] ActRpm   = 2'd2;

  typedef struct packed {
    logic [1:0]            blink;
    logic [MaskW-1:0]      mask;
    logic [ChCount-1:0][7:0] end_col;
    logic [ChCount-1:0][7:0] start_col;
    logic [RpmW-1:0]       end_rpm;
    logic [RpmW-1:0]       start_rpm;
  } entry_t;

  typedef struct packed {
    logic [1:0]              blink;
    logic [ChCount-1:0][7:0] col;
  } led_t;

endpackage

@@ hdl/rlcm_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module rlcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rpm_led_color_mapper.sv @@
// Top level of the rpm LED color mapper: entry table, interpolation engine, LED output.
// A clear or add beat moves to the reply state, which posts its result beat once the
//   output register is free. Rpm beats: each stored entry is read and band-checked; a
//   miss or an entry with equal bounds moves on, a sloped hit runs an 8-step restoring
//   divider per color channel and then applies; a final read closes the walk and the
//   LED results stream out. A new beat is taken only when the last one is fully posted.
// Reset: entry count, state machine, LED buffer and output valid clear; table RAM is
//   not cleared, entries above the count are never read.
`timescale 1ns / 1ps

module rpm_led_color_mapper
  import rlcm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef,
  parameter int unsigned LED_COUNT   = LedCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [RpmW-1:0]    rpm_i,
  input  logic [RpmW-1:0]    start_rpm_i,
  input  logic [RpmW-1:0]    end_rpm_i,
  input  logic [7:0]         start_red_i,
  input  logic [7:0]         start_green_i,
  input  logic [7:0]         start_blue_i,
  input  logic [7:0]         end_red_i,
  input  logic [7:0]         end_green_i,
  input  logic [7:0]         end_blue_i,
  input  logic [MaskW-1:0]   led_mask_i,
  input  logic [1:0]         blink_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LedIdxW-1:0] led_index_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [1:0]         blink_rate_o,
  output logic               accepted_o,
  output logic               last_o
);

  // Table address, entry count, LED index and entry widths.
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned EW = $bits(entry_t);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // take a beat
  localparam logic [2:0] S_REPLY = 3'd1;  // post the single clear/add result
  localparam logic [2:0] S_READ  = 3'd2;  // issue table read for entry k
  localparam logic [2:0] S_CHECK = 3'd3;  // band test, products or flat paint
  localparam logic [2:0] S_DIV   = 3'd4;  // one quotient bit per cycle
  localparam logic [2:0] S_APPLY = 3'd5;  // finish floor, paint masked LEDs
  localparam logic [2:0] S_EMIT  = 3'd6;  // stream LED results

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic          acc_q, acc_d;
  logic [RpmW-1:0] rpm_q, rpm_d;
  logic [LW-1:0] led_cnt_q, led_cnt_d;

  // Interpolation datapath, one lane per color channel.
  logic [RpmW-1:0]               d_q;
  logic [2:0]                    bit_q;
  logic [ChCount-1:0][ProdW-1:0] rem_q;
  logic [ChCount-1:0][QuotW-1:0] quo_q;
  logic [ChCount-1:0]            neg_q;
  logic [ChCount-1:0][7:0]       base_q;
  logic [MaskW-1:0]              mask_q;
  logic [1:0]                    blink_q;

  led_t led_q [LED_COUNT];

  logic       out_valid_q;
  logic       out_free;
  logic       in_fire;

  // Table RAM, one entry per add while the table has room.
  entry_t   wr_entry, rd_entry;
  logic [EW-1:0] rd_raw;
  logic     ram_we, ram_re;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    wr_entry.blink     = blink_code_i;
    wr_entry.mask      = led_mask_i;
    wr_entry.end_col   = {end_blue_i, end_green_i, end_red_i};
    wr_entry.start_col = {start_blue_i, start_green_i, start_red_i};
    wr_entry.end_rpm   = end_rpm_i;
    wr_entry.start_rpm = start_rpm_i;
  end

  assign ram_we = in_fire && (action_i == ActAdd) && (cnt_q < CW'(MAX_ENTRIES));
  assign ram_re = (state_q == S_READ) && (k_q != cnt_q);

  rlcm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // Band test on the entry just read.
  logic            band_hit, band_flat;
  logic [RpmW-1:0] span_n, span_d;
  assign band_hit  = (rpm_q >= rd_entry.start_rpm) && (rpm_q <= rd_entry.end_rpm);
  assign band_flat = (rd_entry.start_rpm == rd_entry.end_rpm);
  assign span_n    = rpm_q - rd_entry.start_rpm;
  assign span_d    = rd_entry.end_rpm - rd_entry.start_rpm;

  // Per-channel magnitude of color delta times rpm offset.
  logic [ChCount-1:0]            ch_neg;
  logic [ChCount-1:0][7:0]       ch_mag;
  logic [ChCount-1:0][ProdW-1:0] ch_prod;
  always_comb begin
    for (int c = 0; c < ChCount; c++) begin
      ch_neg[c]  = rd_entry.end_col[c] < rd_entry.start_col[c];
      ch_mag[c]  = ch_neg[c] ? (rd_entry.start_col[c] - rd_entry.end_col[c])
                             : (rd_entry.end_col[c] - rd_entry.start_col[c]);
      ch_prod[c] = {15'd0, ch_mag[c]} * {8'd0, span_n};
    end
  end

  // Restoring divider step: quotient is known to stay below 256.
  logic [ProdW:0]                dsh;
  logic [ChCount-1:0][ProdW:0]   trial;
  assign dsh = (ProdW + 1)'(d_q) << bit_q;
  always_comb begin
    for (int c = 0; c < ChCount; c++) begin
      trial[c] = {1'b0, rem_q[c]} - dsh;
    end
  end

  // Floor correction: negative deltas round away from zero on a remainder.
  logic [ChCount-1:0][7:0] ch_res;
  logic [ChCount-1:0][8:0] ch_sub;
  always_comb begin
    for (int c = 0; c < ChCount; c++) begin
      ch_sub[c] = {1'b0, quo_q[c]} + 9'(rem_q[c] != '0);
      ch_res[c] = neg_q[c] ? 8'({1'b0, base_q[c]} - ch_sub[c])
                           : 8'(base_q[c] + quo_q[c]);
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    acc_d     = acc_q;
    rpm_d     = rpm_q;
    led_cnt_d = led_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          priority if (action_i == ActClear) begin
            cnt_d   = '0;
            acc_d   = 1'b1;
            state_d = S_REPLY;
          end else if (action_i == ActAdd) begin
            acc_d   = ram_we;
            if (ram_we) begin
              cnt_d = cnt_q + 1'b1;
            end
            state_d = S_REPLY;
          end else if (action_i == ActRpm) begin
            rpm_d   = rpm_i;
            k_d     = '0;
            state_d = S_READ;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (k_q == cnt_q) begin
          led_cnt_d = '0;
          state_d   = S_EMIT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (band_hit && !band_flat) begin
          state_d = S_DIV;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_DIV: begin
        if (bit_q == '0) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        k_d     = k_q + 1'b1;
        state_d = S_READ;
      end
      S_EMIT: begin
        if (out_free) begin
          led_cnt_d = led_cnt_q + 1'b1;
          if (led_cnt_q == LW'(LED_COUNT - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      k_q       <= '0;
      acc_q     <= 1'b0;
      rpm_q     <= '0;
      led_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      acc_q     <= acc_d;
      rpm_q     <= rpm_d;
      led_cnt_q <= led_cnt_d;
    end
  end

  // Divider lanes: load on each band check, then shift one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK) begin
      d_q     <= span_d;
      bit_q   <= 3'(QuotW - 1);
      mask_q  <= rd_entry.mask;
      blink_q <= rd_entry.blink;
      for (int c = 0; c < ChCount; c++) begin
        rem_q[c]  <= ch_prod[c];
        quo_q[c]  <= '0;
        neg_q[c]  <= ch_neg[c];
        base_q[c] <= rd_entry.start_col[c];
      end
    end else if (state_q == S_DIV) begin
      bit_q <= bit_q - 1'b1;
      for (int c = 0; c < ChCount; c++) begin
        if (!trial[c][ProdW]) begin
          rem_q[c]        <= trial[c][ProdW-1:0];
          quo_q[c][bit_q] <= 1'b1;
        end
      end
    end
  end

  // LED buffer: clear on each rpm beat, paint masked LEDs, later entries win.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LED_COUNT; i++) begin
        led_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        priority if (in_fire && (action_i == ActRpm)) begin
          led_q[i] <= '0;
        end else if ((state_q == S_CHECK) && band_hit && band_flat
                     && rd_entry.mask[i]) begin
          led_q[i].col   <= rd_entry.end_col;
          led_q[i].blink <= rd_entry.blink;
        end else if ((state_q == S_APPLY) && mask_q[i]) begin
          led_q[i].col   <= ch_res;
          led_q[i].blink <= blink_q;
        end else begin
          led_q[i] <= led_q[i];
        end
      end
    end
  end

  // Output register: holds one result beat until taken.
  logic               load_reply, load_led;
  logic [LedIdxW-1:0] oidx_q;
  logic [ChCount-1:0][7:0] ocol_q;
  logic [1:0]         oblink_q;
  logic               oacc_q, olast_q;

  assign load_reply = (state_q == S_REPLY) && out_free;
  assign load_led   = (state_q == S_EMIT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_reply || load_led) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_reply) begin
      oidx_q   <= '0;
      ocol_q   <= '0;
      oblink_q <= '0;
      oacc_q   <= acc_q;
      olast_q  <= 1'b1;
    end else if (load_led) begin
      oidx_q   <= LedIdxW'(led_cnt_q);
      ocol_q   <= led_q[led_cnt_q].col;
      oblink_q <= led_q[led_cnt_q].blink;
      oacc_q   <= 1'b0;
      olast_q  <= (led_cnt_q == LW'(LED_COUNT - 1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign led_index_o  = oidx_q;
  assign red_o        = ocol_q[0];
  assign green_o      = ocol_q[1];
  assign blue_o       = ocol_q[2];
  assign blink_rate_o = oblink_q;
  assign accepted_o   = oacc_q;
  assign last_o       = olast_q;

  // Checks.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_read_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (k_q < cnt_q))
    else $error("table read beyond stored entries");

  a_check_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> ($past(state_q) == S_READ))
    else $error("band check without a preceding table read");

  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (!accepted_o && (led_index_o != LedIdxW'(LED_COUNT - 1))))
    else $error("non-final result beat carries final-beat marks");

endmodule
